/* rtl/core/sq8_pkg.sv */
// ----------------------------------------------------------------------------
// sq8_pkg: shared types and constants
// Widths, opcodes, and the state type for the list scan top-k block.
// ----------------------------------------------------------------------------
package sq8_pkg;

  localparam int unsigned DimMax = 64;
  localparam int unsigned KMax   = 16;

  localparam int unsigned DistW  = 40;
  localparam int unsigned IdW    = 31;
  localparam int unsigned CountW = 32;

  localparam logic [DistW-1:0] DistSat = {DistW{1'b1}};

  typedef enum logic [1:0] {
    OpLoad   = 2'd0,
    OpStart  = 2'd1,
    OpCode   = 2'd2,
    OpFinish = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StDecode,
    StEmit
  } state_e;

  localparam logic CfgResultCount = 1'b0;
  localparam logic CfgDimsInUse   = 1'b1;

  // control from the top level to each cell of the kept list
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* rtl/core/sq8_cell.sv */
// ----------------------------------------------------------------------------
// sq8_cell: one slot of the sorted kept list
// Holds a distance and an id; takes the new entry or the left neighbor's one.
// ----------------------------------------------------------------------------
module sq8_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sq8_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        in_range_i,
  input  logic [sq8_pkg::DistW-1:0]   new_dist_i,
  input  logic [sq8_pkg::IdW-1:0]     new_id_i,
  input  logic                        left_valid_i,
  input  logic                        left_greater_i,
  input  logic [sq8_pkg::DistW-1:0]   left_dist_i,
  input  logic [sq8_pkg::IdW-1:0]     left_id_i,
  output logic                        valid_o,
  output logic                        greater_o,
  output logic [sq8_pkg::DistW-1:0]   dist_o,
  output logic [sq8_pkg::IdW-1:0]     id_o
);

  logic                      valid_q, valid_d;
  logic [sq8_pkg::DistW-1:0] dist_q, dist_d;
  logic [sq8_pkg::IdW-1:0]   id_q, id_d;

  // strictly greater: ties keep arrival order
  assign greater_o = valid_q && (dist_q > new_dist_i);
  assign valid_o   = valid_q;
  assign dist_o    = dist_q;
  assign id_o      = id_q;

  always_comb begin
    valid_d = valid_q;
    dist_d  = dist_q;
    id_d    = id_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert && in_range_i) begin
      if (greater_o || !valid_q) begin
        if (left_greater_i) begin
          valid_d = left_valid_i;
          dist_d  = left_dist_i;
          id_d    = left_id_i;
        end else begin
          valid_d = 1'b1;
          dist_d  = new_dist_i;
          id_d    = new_id_i;
        end
      end
    end else if (ctrl_i.shift) begin
      // trim slots beyond k
      if (!in_range_i) valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    id_q   <= id_d;
  end

endmodule

/* rtl/core/sq8_list_scan_topk.sv */
// ----------------------------------------------------------------------------
// sq8_list_scan_topk: scalar-quantized list scan with sorted top-k
// Decodes 8-bit codes, accumulates squared distance, keeps the k nearest.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  command   | start / busy              | opcode, dim_index, query/min/step,
//            |                           | code_byte, entry_id
//  config    | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//  result    | result_valid_o (strobe)   | id, distance, rank, count, flags
//
//  load and start are taken while idle; a code byte goes through a table read,
//  multiply/decode, and square and accumulate through the shared datapath
//  finish then emits one result per cycle: one per kept entry, or a single
//  result when the list is empty
//  the kept list is a row of cells; an insert updates all cells in the same cycle
//  reset clears control state; the tables hold garbage until loaded
//  results are strobes; the receiver cannot stall
module sq8_list_scan_topk #(
  parameter int unsigned DIM_MAX = sq8_pkg::DimMax,
  parameter int unsigned K_MAX   = sq8_pkg::KMax
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [5:0]                    dim_index_i,
  input  logic signed [15:0]            query_value_i,
  input  logic signed [15:0]            min_value_i,
  input  logic [15:0]                   step_value_i,
  input  logic [7:0]                    code_byte_i,
  input  logic [sq8_pkg::IdW-1:0]       entry_id_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [6:0]                    cfg_wdata_i,
  output logic                          result_valid_o,
  output logic [sq8_pkg::IdW-1:0]       result_id_o,
  output logic [sq8_pkg::DistW-1:0]     result_distance_o,
  output logic [3:0]                    rank_o,
  output logic [sq8_pkg::CountW-1:0]    candidate_count_o,
  output logic                          empty_flag_o,
  output logic                          last_o
);

  localparam int unsigned DimW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int unsigned KW   = $clog2(K_MAX + 1);
  localparam int unsigned KIdxW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  // configuration registers
  logic [4:0] result_count_q;
  logic [6:0] dims_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_count_q <= 5'd10;
      dims_in_use_q  <= 7'd32;
    end else if (cfg_we_i) begin
      if (cfg_index_i == sq8_pkg::CfgResultCount) result_count_q <= cfg_wdata_i[4:0];
      else                                         dims_in_use_q  <= cfg_wdata_i;
    end
  end

  // clamped k and dims
  logic [KW-1:0] k_eff;
  logic [8:0]    dims_eff;
  always_comb begin
    if (result_count_q == 5'd0)                 k_eff = KW'(1);
    else if (32'(result_count_q) > K_MAX)       k_eff = KW'(K_MAX);
    else                                        k_eff = KW'(result_count_q);
    if (dims_in_use_q == 7'd0)                  dims_eff = 9'd1;
    else if (32'(dims_in_use_q) > DIM_MAX)      dims_eff = 9'(DIM_MAX);
    else                                        dims_eff = 9'(dims_in_use_q);
  end

  // per-dimension tables, one memory each
  logic [15:0] query_mem [DIM_MAX];
  logic [15:0] min_mem   [DIM_MAX];
  logic [15:0] step_mem  [DIM_MAX];
  logic [15:0] query_rd_q, min_rd_q, step_rd_q;

  logic accept;
  assign accept = start && !busy;

  sq8_pkg::op_e op;
  assign op = sq8_pkg::op_e'(opcode_i);

  always_ff @(posedge clk_i) begin
    if (accept && op == sq8_pkg::OpLoad && 32'(dim_index_i) < DIM_MAX) begin
      query_mem[dim_index_i[DimW-1:0]] <= query_value_i;
      min_mem[dim_index_i[DimW-1:0]]   <= min_value_i;
      step_mem[dim_index_i[DimW-1:0]]  <= step_value_i;
    end
  end

  logic [8:0] byte_pos_q, byte_pos_d;
  logic [DimW-1:0] rd_addr;
  assign rd_addr = (32'(byte_pos_q) < DIM_MAX) ? byte_pos_q[DimW-1:0] : DimW'(DIM_MAX - 1);

  always_ff @(posedge clk_i) begin
    query_rd_q <= query_mem[rd_addr];
    min_rd_q   <= min_mem[rd_addr];
    step_rd_q  <= step_mem[rd_addr];
  end

  // sequencer
  sq8_pkg::state_e state_q, state_d;
  logic [7:0]  code_q;
  logic [sq8_pkg::IdW-1:0] id_q;
  logic signed [17:0] diff_q;
  logic [sq8_pkg::DistW-1:0] acc_q, acc_d;
  logic [sq8_pkg::CountW-1:0] scanned_q, scanned_d;
  logic [KW-1:0] kept_q, kept_d;
  logic [KIdxW-1:0] emit_q, emit_d;
  logic sq_phase_q, sq_phase_d;

  // decode: min + round(code*step >> 8) - query
  logic [23:0] prod;
  logic [16:0] frac_add;
  logic signed [17:0] diff_c;
  assign prod     = code_q * step_rd_q;
  assign frac_add = 17'((25'(prod) + 25'd128) >> 8);
  assign diff_c   = 18'(signed'(min_rd_q)) + signed'({1'b0, frac_add})
                  - 18'(signed'(query_rd_q));

  logic [17:0] mag;
  logic [35:0] sq;
  logic [sq8_pkg::DistW:0] sum;
  assign mag = diff_q[17] ? 18'(-diff_q) : 18'(diff_q);
  assign sq  = mag * mag;
  assign sum = {1'b0, acc_q} + (sq8_pkg::DistW + 1)'(sq);

  logic [sq8_pkg::DistW-1:0] sum_sat;
  assign sum_sat = sum[sq8_pkg::DistW] ? sq8_pkg::DistSat : sum[sq8_pkg::DistW-1:0];

  logic entry_done;
  assign entry_done = (byte_pos_q + 9'd1) >= dims_eff;

  sq8_pkg::cell_ctrl_t ctrl;
  logic [KW-1:0] n_eff;
  assign n_eff = (kept_q < k_eff) ? kept_q : k_eff;

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    byte_pos_d = byte_pos_q;
    scanned_d  = scanned_q;
    kept_d     = kept_q;
    emit_d     = emit_q;
    sq_phase_d = sq_phase_q;
    ctrl       = '0;
    busy       = 1'b1;
    case (state_q)
      sq8_pkg::StIdle: begin
        busy = 1'b0;
        if (accept) begin
          case (op)
            sq8_pkg::OpStart: begin
              ctrl.clear = 1'b1;
              kept_d     = '0;
              scanned_d  = '0;
              acc_d      = '0;
              byte_pos_d = '0;
            end
            sq8_pkg::OpCode: begin
              state_d    = sq8_pkg::StDecode;
              sq_phase_d = 1'b0;
            end
            sq8_pkg::OpFinish: begin
              // finish reads the list and leaves the kept list, accumulator and scan count alone
              state_d = sq8_pkg::StEmit;
              emit_d  = '0;
            end
            default: ;
          endcase
        end
      end
      sq8_pkg::StDecode: begin
        if (!sq_phase_q) begin
          sq_phase_d = 1'b1;
        end else begin
          state_d = sq8_pkg::StIdle;
          if (entry_done) begin
            ctrl.insert = 1'b1;
            ctrl.shift  = 1'b1;
            kept_d = (n_eff < k_eff) ? n_eff + KW'(1) : n_eff;
            if (scanned_q != '1) scanned_d = scanned_q + 1'b1;
            acc_d      = '0;
            byte_pos_d = '0;
          end else begin
            acc_d      = sum_sat;
            byte_pos_d = byte_pos_q + 9'd1;
          end
        end
      end
      sq8_pkg::StEmit: begin
        if (n_eff == '0 || KW'(emit_q) + KW'(1) >= n_eff) state_d = sq8_pkg::StIdle;
        else emit_d = emit_q + 1'b1;
      end
      default: state_d = sq8_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sq8_pkg::StIdle;
      acc_q      <= '0;
      byte_pos_q <= '0;
      scanned_q  <= '0;
      kept_q     <= '0;
      emit_q     <= '0;
      sq_phase_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      byte_pos_q <= byte_pos_d;
      scanned_q  <= scanned_d;
      kept_q     <= kept_d;
      emit_q     <= emit_d;
      sq_phase_q <= sq_phase_d;
    end
  end

  // payload captures
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q <= code_byte_i;
      id_q   <= entry_id_i;
    end
    if (state_q == sq8_pkg::StDecode && !sq_phase_q) diff_q <= diff_c;
  end

  // row of kept-list cells, neighbor chain from slot 0 upward
  logic                      c_valid   [K_MAX];
  logic                      c_greater [K_MAX];
  logic [sq8_pkg::DistW-1:0] c_dist    [K_MAX];
  logic [sq8_pkg::IdW-1:0]   c_id      [K_MAX];

  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    logic in_range, lv, lg;
    logic [sq8_pkg::DistW-1:0] ld;
    logic [sq8_pkg::IdW-1:0]   li;
    assign in_range = KW'(g) < k_eff;
    if (g == 0) begin : g_first
      assign lv = 1'b0;
      assign lg = 1'b0;
      assign ld = '0;
      assign li = '0;
    end else begin : g_rest
      assign lv = c_valid[g-1];
      assign lg = c_greater[g-1] || (!c_valid[g-1] && 1'b0);
      assign ld = c_dist[g-1];
      assign li = c_id[g-1];
    end
    sq8_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .in_range_i     (in_range && (KW'(g) <= n_eff)),
      .new_dist_i     (sum_sat),
      .new_id_i       (id_q),
      .left_valid_i   (lv),
      .left_greater_i (lg),
      .left_dist_i    (ld),
      .left_id_i      (li),
      .valid_o        (c_valid[g]),
      .greater_o      (c_greater[g]),
      .dist_o         (c_dist[g]),
      .id_o           (c_id[g])
    );
  end

  // result strobe
  logic emitting;
  assign emitting = state_q == sq8_pkg::StEmit;
  assign result_valid_o    = emitting;
  assign empty_flag_o      = emitting && n_eff == '0;
  assign last_o            = emitting && (n_eff == '0 || KW'(emit_q) + KW'(1) >= n_eff);
  assign result_id_o       = (n_eff == '0) ? '0 : c_id[emit_q];
  assign result_distance_o = (n_eff == '0) ? '0 : c_dist[emit_q];
  assign rank_o            = (n_eff == '0) ? 4'd0 : 4'(emit_q);
  assign candidate_count_o = (n_eff == '0) ? '0 : scanned_q;

endmodule

/* dv/sq8_list_scan_topk_tb.sv */
// ----------------------------------------------------------------------------
// sq8_list_scan_topk_tb: self-checking testbench for the sq8 list scan top-k
// Drives load, start, code byte and finish commands with bursty idling, runs
// a cycle-accurate-free predictor of the kept list, and checks every result
// strobe field by field against the oldest expected transaction.
// ----------------------------------------------------------------------------
module sq8_list_scan_topk_tb;
  import sq8_pkg::*;

  // one expected or observed result transaction
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [DistW-1:0]  distance;
    logic [3:0]        rank;
    logic [CountW-1:0] count;
    logic              empty;
    logic              last;
  } hit_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        opcode_i;
  logic [5:0]        dim_index_i;
  logic signed [15:0] query_value_i;
  logic signed [15:0] min_value_i;
  logic [15:0]       step_value_i;
  logic [7:0]        code_byte_i;
  logic [IdW-1:0]    entry_id_i;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [6:0]        cfg_wdata_i;
  logic              result_valid_o;
  logic [IdW-1:0]    result_id_o;
  logic [DistW-1:0]  result_distance_o;
  logic [3:0]        rank_o;
  logic [CountW-1:0] candidate_count_o;
  logic              empty_flag_o;
  logic              last_o;

  sq8_list_scan_topk dut (.*);

  // predictor state, mirrors the block's architectural state
  logic [15:0]       query_tab [DimMax];
  logic [15:0]       min_tab   [DimMax];
  logic [15:0]       step_tab  [DimMax];
  logic [DistW-1:0]  dist_acc;
  int unsigned       byte_pos;
  logic [DistW-1:0]  near_dist [KMax];
  logic [IdW-1:0]    near_id   [KMax];
  int unsigned       kept_cnt;
  logic [CountW-1:0] scan_cnt;
  logic [4:0]        k_reg;
  logic [6:0]        dims_reg;

  hit_t        pending_hits [$];
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned burst_left;
  longint unsigned cycle_cnt;

  localparam longint unsigned CycleLimit = 400000;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("sq8_list_scan_topk_tb failed");
      $finish;
    end
  end

  function automatic int unsigned k_now();
    if (k_reg < 1) return 1;
    if (k_reg > KMax) return KMax;
    return k_reg;
  endfunction

  function automatic int unsigned dims_now();
    if (dims_reg < 1) return 1;
    if (dims_reg > DimMax) return DimMax;
    return dims_reg;
  endfunction

  // append one expected transaction at the tail of the queue
  task automatic queue_hit(input hit_t h);
    pending_hits.insert(pending_hits.size(), h);
  endtask

  // sorted insert; strictly smaller distance displaces, ties keep arrival order
  task automatic keep_nearest(input logic [DistW-1:0] d, input logic [IdW-1:0] id);
    int unsigned k, n, p, last_slot;
    k = k_now();
    n = (kept_cnt < k) ? kept_cnt : k;
    p = 0;
    while (p < n && near_dist[p] <= d) p++;
    if (p >= k) begin
      kept_cnt = n;
      return;
    end
    last_slot = (n < k) ? n : k - 1;
    for (int i = last_slot; i > p; i--) begin
      near_dist[i] = near_dist[i-1];
      near_id[i]   = near_id[i-1];
    end
    near_dist[p] = d;
    near_id[p]   = id;
    if (n < k) n++;
    kept_cnt = n;
  endtask

  // update predictor for one accepted command, queue any results it causes
  task automatic predict_command();
    int unsigned j, n, k;
    longint prod, decoded, diff;
    longint unsigned sum;
    hit_t h;
    case (op_e'(opcode_i))
      OpLoad: begin
        query_tab[dim_index_i] = query_value_i;
        min_tab[dim_index_i]   = min_value_i;
        step_tab[dim_index_i]  = step_value_i;
      end
      OpStart: begin
        kept_cnt = 0;
        scan_cnt = '0;
        dist_acc = '0;
        byte_pos = 0;
      end
      OpCode: begin
        j = (byte_pos < DimMax) ? byte_pos : DimMax - 1;
        prod    = longint'(code_byte_i) * longint'(step_tab[j]);
        decoded = longint'($signed(min_tab[j])) + ((prod + 128) >>> 8);
        diff    = decoded - longint'($signed(query_tab[j]));
        sum     = longint'(dist_acc) + diff * diff;
        if (sum > longint'(DistSat)) sum = DistSat;
        if (byte_pos + 1 >= dims_now()) begin
          keep_nearest(sum[DistW-1:0], entry_id_i);
          if (scan_cnt != '1) scan_cnt++;
          dist_acc = '0;
          byte_pos = 0;
        end else begin
          dist_acc = sum[DistW-1:0];
          byte_pos++;
        end
      end
      default: begin
        k = k_now();
        n = (kept_cnt < k) ? kept_cnt : k;
        if (n == 0) begin
          h = '0;
          h.empty = 1'b1;
          h.last  = 1'b1;
          queue_hit(h);
        end
        for (int i = 0; i < n; i++) begin
          h.id       = near_id[i];
          h.distance = near_dist[i];
          h.rank     = i[3:0];
          h.count    = scan_cnt;
          h.empty    = 1'b0;
          h.last     = (i + 1 == n);
          queue_hit(h);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_cnt++;
  endtask

  // result checker; the receiver never stalls
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected result", result_id_o, 0);
      end else begin
        want = pending_hits.pop_front();
        if (result_id_o !== want.id) report_mismatch("id", result_id_o, want.id);
        if (result_distance_o !== want.distance)
          report_mismatch("distance", result_distance_o, want.distance);
        if (rank_o !== want.rank) report_mismatch("rank", rank_o, want.rank);
        if (candidate_count_o !== want.count)
          report_mismatch("count", candidate_count_o, want.count);
        if (empty_flag_o !== want.empty) report_mismatch("empty", empty_flag_o, want.empty);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  // send one command transaction; sender idles in bursts
  task automatic send_cmd(input op_e op, input logic [5:0] dim, input logic [15:0] qv,
                          input logic [15:0] mv, input logic [15:0] sv,
                          input logic [7:0] cb, input logic [IdW-1:0] eid);
    start         <= 1'b1;
    opcode_i      <= op;
    dim_index_i   <= dim;
    query_value_i <= qv;
    min_value_i   <= mv;
    step_value_i  <= sv;
    code_byte_i   <= cb;
    entry_id_i    <= eid;
    do @(posedge clk_i); while (busy);
    predict_command();
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // random fields everywhere, only the named ones matter
  task automatic send_op(input op_e op, input logic [7:0] cb, input logic [IdW-1:0] eid);
    send_cmd(op, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), cb, eid);
  endtask

  // drain results, then let an in-flight code byte settle
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [6:0] val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgResultCount) k_reg = val[4:0];
    else dims_reg = val;
  endtask

  // one entry of random codes, extremes now and then
  task automatic send_entry();
    int unsigned dn;
    dn = dims_now();
    for (int b = 0; b < dn; b++)
      send_op(OpCode, ($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom),
              IdW'($urandom));
  endtask

  // every table slot written before any read
  task automatic test_load_tables();
    for (int d = 0; d < DimMax; d++) begin
      case (d)
        0:       send_cmd(OpLoad, 6'(d), 16'h8000, 16'h7fff, 16'hffff, 8'h00, '0);
        1:       send_cmd(OpLoad, 6'(d), 16'h7fff, 16'h8000, 16'h0000, 8'hff, '1);
        2:       send_cmd(OpLoad, 6'(d), 16'h8000, 16'h8000, 16'hffff, 8'h00, '0);
        default: send_cmd(OpLoad, 6'(d), 16'($urandom), 16'($urandom), 16'($urandom),
                          8'($urandom), IdW'($urandom));
      endcase
    end
  endtask

  // code bytes before any start, then finish with and without candidates
  task automatic test_empty_and_early();
    write_cfg(CfgDimsInUse, 7'd1);
    send_op(OpFinish, 8'h00, '0);
    send_op(OpCode, 8'hff, '1);
    send_op(OpCode, 8'h00, '0);
    send_op(OpFinish, 8'h00, '0);
    send_op(OpStart, 8'h00, '0);
    send_op(OpFinish, 8'h00, '0);
  endtask

  // extreme codes/ids, ties, partial entry kept across finish
  task automatic test_extremes_and_ties();
    write_cfg(CfgResultCount, 7'd0);
    write_cfg(CfgDimsInUse, 7'd2);
    send_op(OpStart, 8'h00, '0);
    send_op(OpCode, 8'h00, IdW'(5));
    send_op(OpCode, 8'hff, '1);
    send_op(OpCode, 8'h00, IdW'(7));
    send_op(OpCode, 8'hff, '0);
    send_op(OpCode, 8'h11, IdW'(9));
    send_op(OpFinish, 8'h00, '0);
    write_cfg(CfgResultCount, 7'd31);
    send_op(OpCode, 8'h22, IdW'(3));
    send_op(OpFinish, 8'h00, '0);
  endtask

  // random scans over several register settings
  task automatic test_random_scans();
    int unsigned n_ent;
    while (items_sent < 370) begin
      case ($urandom_range(0, 7))
        0:       write_cfg(CfgResultCount, 7'd1);
        1:       write_cfg(CfgResultCount, 7'd16);
        2:       write_cfg(CfgDimsInUse, 7'd64);
        3:       write_cfg(CfgDimsInUse, 7'd127);
        default: begin
          write_cfg(CfgResultCount, 7'($urandom_range(1, 16)));
          write_cfg(CfgDimsInUse, 7'($urandom_range(1, 6)));
        end
      endcase
      n_ent = (dims_now() > 8) ? $urandom_range(1, 3) : $urandom_range(0, 20);
      if ($urandom_range(0, 5) != 0) send_op(OpStart, 8'h00, '0);
      for (int e = 0; e < n_ent; e++) begin
        if (items_sent >= 370) break;
        case ($urandom_range(0, 9))
          0:       send_cmd(OpLoad, 6'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 8'($urandom), IdW'($urandom));
          1:       send_op(OpFinish, 8'h00, '0);
          2:       send_op(OpCode, 8'($urandom), IdW'($urandom));
          default: ;
        endcase
        send_entry();
      end
      send_op(OpFinish, 8'h00, '0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    opcode_i      = '0;
    dim_index_i   = '0;
    query_value_i = '0;
    min_value_i   = '0;
    step_value_i  = '0;
    code_byte_i   = '0;
    entry_id_i    = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_wdata_i   = '0;
    cycle_cnt     = 0;
    err_cnt       = 0;
    items_sent    = 0;
    burst_left    = 0;
    k_reg         = 5'd10;
    dims_reg      = 7'd32;
    dist_acc      = '0;
    byte_pos      = 0;
    kept_cnt      = 0;
    scan_cnt      = '0;
    for (int i = 0; i < KMax; i++) begin
      near_dist[i] = '0;
      near_id[i]   = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_load_tables();
    test_empty_and_early();
    test_extremes_and_ties();
    test_random_scans();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_hits.size() == 0) begin
      $display("sq8_list_scan_topk_tb passed");
    end else begin
      $display("sq8_list_scan_topk_tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sq8_pkg.sv
rtl/core/sq8_cell.sv
rtl/core/sq8_list_scan_topk.sv
dv/sq8_list_scan_topk_tb.sv
